>>> rtl/stok_pkg.sv
// ----------------------------------------------------------------------------
// stok_pkg
// Shared types, character codes and keyword tables of the source tokenizer.
// ----------------------------------------------------------------------------
package stok_pkg;

    localparam int POSITION_BITS_DEFAULT = 24;
    localparam int FIELD_BITS            = 24;
    localparam int QUEUE_DEPTH           = 4;
    localparam int KW_COUNT              = 5;
    localparam int KW_MAX_LEN            = 8;

    typedef enum logic [3:0] {
        KIND_VOID    = 4'd0,
        KIND_INT     = 4'd1,
        KIND_STRING  = 4'd2,
        KIND_FOREIGN = 4'd3,
        KIND_STRLIT  = 4'd4,
        KIND_RETURN  = 4'd5,
        KIND_INTLIT  = 4'd6,
        KIND_LPAREN  = 4'd7,
        KIND_RPAREN  = 4'd8,
        KIND_LBRACE  = 4'd9,
        KIND_RBRACE  = 4'd10,
        KIND_SEMI    = 4'd11,
        KIND_COMMA   = 4'd12,
        KIND_IDENT   = 4'd13,
        KIND_EOF     = 4'd14,
        KIND_ERROR   = 4'd15
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE         = 2'd0,
        ERR_UNTERMINATED = 2'd1,
        ERR_SPECIAL_WORD = 2'd2,
        ERR_UNEXPECTED   = 2'd3
    } err_t;

    typedef enum logic [6:0] {
        PH_IDLE    = 7'b0000001,
        PH_COMMENT = 7'b0000010,
        PH_IDENT   = 7'b0000100,
        PH_SPECIAL = 7'b0001000,
        PH_NUMBER  = 7'b0010000,
        PH_STRING  = 7'b0100000,
        PH_ESCAPE  = 7'b1000000
    } phase_t;

    typedef struct packed {
        kind_t                   kind;
        err_t                    err;
        logic [FIELD_BITS-1:0]   start;
        logic [FIELD_BITS-1:0]   length;
        logic [FIELD_BITS-1:0]   line;
        logic                    last;
    } tok_t;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_SEMI      = 8'h3B;
    localparam logic [7:0] CH_AT        = 8'h40;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDERLINE = 8'h5F;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;

    localparam logic [KW_COUNT-1:0] CAND_ALL     = 5'b11111;
    localparam logic [KW_COUNT-1:0] CAND_FOREIGN = 5'b01000;

    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
        '{"S", "t", "r", "i", "n", "g", 8'h00, 8'h00},
        '{"@", "f", "o", "r", "e", "i", "g", "n"},
        '{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd3, 4'd6, 4'd6, 4'd8, 4'd4};
    localparam kind_t KW_KIND [KW_COUNT] =
        '{KIND_INT, KIND_RETURN, KIND_STRING, KIND_FOREIGN, KIND_VOID};

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == CH_UNDERLINE;
    endfunction

    // candidates whose byte at this offset equals c
    function automatic logic [KW_COUNT-1:0] kw_keep(
        input logic [7:0] c,
        input logic [2:0] off,
        input logic       off_ok
    );
        logic [KW_COUNT-1:0] keep;
        for (int k = 0; k < KW_COUNT; k++) begin
            keep[k] = off_ok && ({1'b0, off} < KW_LEN[k]) && (KW_TEXT[k][off] == c);
        end
        return keep;
    endfunction

    // first live candidate whose length matches
    function automatic logic [4:0] kw_match(
        input logic [KW_COUNT-1:0] cand,
        input logic [3:0]          len,
        input logic                len_ok
    );
        logic [4:0] res;
        res = {1'b0, KIND_IDENT};
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (cand[k] && len_ok && len == KW_LEN[k]) begin
                res = {1'b1, KW_KIND[k]};
            end
        end
        return res;
    endfunction

endpackage

>>> rtl/stok_scanner.sv
// ----------------------------------------------------------------------------
// stok_scanner
// Scan state and per-byte decode; yields up to two tokens per byte.
// ----------------------------------------------------------------------------
module stok_scanner #(
    parameter int POSITION_BITS = stok_pkg::POSITION_BITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    ch,
    output stok_pkg::tok_t res0,
    output stok_pkg::tok_t res1,
    output logic [1:0]    res_count
);
    import stok_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [FIELD_BITS-1:0]    LINE_MAX = '1;

    phase_t                    phase_reg, phase_next;
    logic [FIELD_BITS-1:0]     line_reg, line_next;
    logic [POSITION_BITS-1:0]  pos_reg, pos_next;
    logic [POSITION_BITS-1:0]  tstart_reg, tstart_next;
    logic [KW_COUNT-1:0]       cand_reg, cand_next;

    logic [POSITION_BITS-1:0]  len;
    logic [31:0]               len_wide, pos_wide, ts_wide;
    logic [FIELD_BITS-1:0]     len24, pos24, ts24;
    logic                      word_c, off_ok, len_ok;
    logic [KW_COUNT-1:0]       keep;
    logic [4:0]                found;
    logic                      go_idle, do_reset, a_v, b_v;
    tok_t                      a, b;

    assign len      = pos_reg - tstart_reg;
    assign len_wide = 32'(len);
    assign pos_wide = 32'(pos_reg);
    assign ts_wide  = 32'(tstart_reg);
    assign len24    = len_wide[FIELD_BITS-1:0];
    assign pos24    = pos_wide[FIELD_BITS-1:0];
    assign ts24     = ts_wide[FIELD_BITS-1:0];
    assign word_c   = is_word(ch);
    assign off_ok   = (len[POSITION_BITS-1:3] == '0);
    assign len_ok   = (len[POSITION_BITS-1:4] == '0);
    assign keep     = kw_keep(ch, len[2:0], off_ok);
    assign found    = kw_match(cand_reg, len[3:0], len_ok);

    always_comb
    begin
        phase_next  = phase_reg;
        line_next   = line_reg;
        tstart_next = tstart_reg;
        cand_next   = cand_reg;
        go_idle     = 1'b0;
        do_reset    = 1'b0;
        a_v         = 1'b0;
        b_v         = 1'b0;
        a           = '{kind: KIND_VOID, err: ERR_NONE, start: ts24, length: len24,
                        line: line_reg, last: 1'b1};
        b           = '{kind: KIND_VOID, err: ERR_NONE, start: pos24,
                        length: FIELD_BITS'(1), line: line_reg, last: 1'b1};

        unique case (phase_reg)
            PH_COMMENT:
            begin
                if (ch == CH_LF || ch == CH_NUL)
                begin
                    phase_next = PH_IDLE;
                    go_idle    = 1'b1;
                end
            end
            PH_IDENT:
            begin
                if (word_c)
                begin
                    cand_next = cand_reg & keep;
                end
                else
                begin
                    a_v        = 1'b1;
                    a.kind     = kind_t'(found[3:0]);
                    phase_next = PH_IDLE;
                    go_idle    = 1'b1;
                end
            end
            PH_SPECIAL:
            begin
                if (word_c)
                begin
                    cand_next = cand_reg & keep;
                end
                else if (!found[4])
                begin
                    a_v      = 1'b1;
                    a.kind   = KIND_ERROR;
                    a.err    = ERR_SPECIAL_WORD;
                    do_reset = 1'b1;
                end
                else
                begin
                    a_v        = 1'b1;
                    a.kind     = kind_t'(found[3:0]);
                    phase_next = PH_IDLE;
                    go_idle    = 1'b1;
                end
            end
            PH_NUMBER:
            begin
                if (!is_digit(ch))
                begin
                    a_v        = 1'b1;
                    a.kind     = KIND_INTLIT;
                    phase_next = PH_IDLE;
                    go_idle    = 1'b1;
                end
            end
            PH_STRING:
            begin
                if (ch == CH_BACKSLASH)
                begin
                    phase_next = PH_ESCAPE;
                end
                else if (ch == CH_QUOTE)
                begin
                    a_v        = 1'b1;
                    a.kind     = KIND_STRLIT;
                    a.length   = len24 + FIELD_BITS'(1);
                    phase_next = PH_IDLE;
                end
                else if (ch == CH_NUL)
                begin
                    a_v      = 1'b1;
                    a.kind   = KIND_ERROR;
                    a.err    = ERR_UNTERMINATED;
                    do_reset = 1'b1;
                end
            end
            PH_ESCAPE:
            begin
                if (ch == CH_NUL)
                begin
                    a_v      = 1'b1;
                    a.kind   = KIND_ERROR;
                    a.err    = ERR_UNTERMINATED;
                    do_reset = 1'b1;
                end
                else
                begin
                    phase_next = PH_STRING;
                end
            end
            PH_IDLE:
            begin
                go_idle = 1'b1;
            end
            default:
            begin
                phase_next = PH_IDLE;
                go_idle    = 1'b1;
            end
        endcase

        if (go_idle)
        begin
            unique case (ch)
                CH_SPACE, CH_TAB, CH_CR:
                begin
                end
                CH_LF:
                begin
                    if (line_reg != LINE_MAX)
                    begin
                        line_next = line_reg + FIELD_BITS'(1);
                    end
                end
                CH_HASH:
                begin
                    phase_next = PH_COMMENT;
                end
                CH_NUL:
                begin
                    b_v      = 1'b1;
                    b.kind   = KIND_EOF;
                    do_reset = 1'b1;
                end
                CH_LPAREN: begin b_v = 1'b1; b.kind = KIND_LPAREN; end
                CH_RPAREN: begin b_v = 1'b1; b.kind = KIND_RPAREN; end
                CH_LBRACE: begin b_v = 1'b1; b.kind = KIND_LBRACE; end
                CH_RBRACE: begin b_v = 1'b1; b.kind = KIND_RBRACE; end
                CH_SEMI:   begin b_v = 1'b1; b.kind = KIND_SEMI;   end
                CH_COMMA:  begin b_v = 1'b1; b.kind = KIND_COMMA;  end
                default:
                begin
                    tstart_next = pos_reg;
                    if (ch == CH_QUOTE)
                    begin
                        phase_next = PH_STRING;
                    end
                    else if (ch == CH_AT)
                    begin
                        phase_next = PH_SPECIAL;
                        cand_next  = CAND_FOREIGN;
                    end
                    else if (is_digit(ch))
                    begin
                        phase_next = PH_NUMBER;
                    end
                    else if (is_alpha(ch) || ch == CH_UNDERLINE)
                    begin
                        phase_next = PH_IDENT;
                        cand_next  = CAND_ALL & kw_keep(ch, 3'd0, 1'b1);
                    end
                    else
                    begin
                        b_v      = 1'b1;
                        b.kind   = KIND_ERROR;
                        b.err    = ERR_UNEXPECTED;
                        do_reset = 1'b1;
                    end
                end
            endcase
        end

        if (do_reset)
        begin
            phase_next  = PH_IDLE;
            line_next   = FIELD_BITS'(1);
            pos_next    = '0;
            tstart_next = '0;
            cand_next   = CAND_ALL;
        end
        else if (pos_reg != POS_MAX)
        begin
            pos_next = pos_reg + POSITION_BITS'(1);
        end
        else
        begin
            pos_next = pos_reg;
        end
    end

    always_comb
    begin
        res0      = a_v ? a : b;
        res1      = b;
        res0.last = !(a_v && b_v);
        res1.last = 1'b1;
        res_count = {1'b0, a_v} + {1'b0, b_v};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            line_reg   <= FIELD_BITS'(1);
            pos_reg    <= '0;
            tstart_reg <= '0;
            cand_reg   <= CAND_ALL;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            line_reg   <= line_next;
            pos_reg    <= pos_next;
            tstart_reg <= tstart_next;
            cand_reg   <= cand_next;
        end
    end

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != '0)
        else $error("line counter reached zero");

    a_reset_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        accept && do_reset |=> pos_reg == '0 && line_reg == FIELD_BITS'(1)
            && phase_reg == PH_IDLE)
        else $error("scan state not restarted after eof or error");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_count == 2'd2 |-> res0.kind != KIND_ERROR && !res0.last)
        else $error("second token follows an error token");

    a_token_inside: assert property (@(posedge clk) disable iff (!rst_n)
        tstart_reg <= pos_reg)
        else $error("token start beyond current position");

endmodule

>>> rtl/stok_queue.sv
// ----------------------------------------------------------------------------
// stok_queue
// Result queue taking up to two tokens per cycle and handing out one.
// ----------------------------------------------------------------------------
module stok_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [1:0]     push_count,
    input  stok_pkg::tok_t w0,
    input  stok_pkg::tok_t w1,
    input  logic           pop,
    output stok_pkg::tok_t head,
    output logic           not_empty,
    output logic           full_for_pair
);
    import stok_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    tok_t                mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wptr_reg, wptr_next, rptr_reg, rptr_next, wptr_plus;
    logic [CNT_BITS-1:0] count_reg, count_next;

    assign wptr_plus     = wptr_reg + PTR_BITS'(1);
    assign wptr_next     = wptr_reg + PTR_BITS'(push_count);
    assign rptr_next     = rptr_reg + PTR_BITS'(pop);
    assign count_next    = count_reg + CNT_BITS'(push_count) - CNT_BITS'(pop);
    assign head          = mem[rptr_reg];
    assign not_empty     = (count_reg != '0);
    assign full_for_pair = (count_reg > CNT_BITS'(QUEUE_DEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem[wptr_reg] <= w0;
        end
        if (push_count == 2'd2)
        begin
            mem[wptr_plus] <= w1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_count != 2'd0 |-> count_reg <= CNT_BITS'(QUEUE_DEPTH - 2))
        else $error("transfer into result queue without room for two tokens");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("read from empty result queue");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(QUEUE_DEPTH))
        else $error("result queue count out of range");

endmodule

>>> rtl/source_tokenizer.sv
// ----------------------------------------------------------------------------
// source_tokenizer
// Byte-stream lexer: one source byte in, zero to two tokens out.
// ----------------------------------------------------------------------------
// Takes one source byte per cycle unless stalled (byte 0 ends the source) and
// emits tokens carrying kind, error code, start offset, length and line
// number, one per output transfer. Each byte is decoded in the cycle it is
// accepted and its tokens go to a four-entry result queue feeding the output;
// a byte that closes an identifier, number or '@' word on a delimiter gives
// two tokens, marked by last on the second. The input stalls while the queue
// holds more than two tokens, so with the output taking one token per cycle
// the sustained rate is one byte per cycle. After eof or an error token the
// scan restarts at offset 0, line 1; there is no clearing pass after reset.
module source_tokenizer #(
    parameter int POSITION_BITS = stok_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       ch,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [3:0]                       kind,
    output logic [1:0]                       error_code,
    output logic [stok_pkg::FIELD_BITS-1:0]  start_offset,
    output logic [stok_pkg::FIELD_BITS-1:0]  token_bytes,
    output logic [stok_pkg::FIELD_BITS-1:0]  line_number,
    output logic                             last
);
    import stok_pkg::*;

    logic       accept, pop, full_for_pair;
    logic [1:0] res_count, push_count;
    tok_t       res0, res1, head;

    assign accept     = in_valid && !in_stall;
    assign in_stall   = full_for_pair;
    assign pop        = out_valid && !out_stall;
    assign push_count = accept ? res_count : 2'd0;

    stok_scanner #(
        .POSITION_BITS (POSITION_BITS)
    ) u_scanner (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .ch        (ch),
        .res0      (res0),
        .res1      (res1),
        .res_count (res_count)
    );

    stok_queue u_queue (
        .clk           (clk),
        .rst_n         (rst_n),
        .push_count    (push_count),
        .w0            (res0),
        .w1            (res1),
        .pop           (pop),
        .head          (head),
        .not_empty     (out_valid),
        .full_for_pair (full_for_pair)
    );

    assign kind         = head.kind;
    assign error_code   = head.err;
    assign start_offset = head.start;
    assign token_bytes  = head.length;
    assign line_number  = head.line;
    assign last         = head.last;

endmodule
